// ----- src/dlasc_pkg.sv -----
// Shared types and constants for the decimal limb add/subtract/compare core.
`default_nettype none
package dlasc_pkg;

  localparam int unsigned LimbW = 27;
  localparam int unsigned SumW  = 30;
  localparam int unsigned CarryW = 3;

  localparam logic signed [SumW-1:0] BaseP1 = 30'sd100000000;
  localparam logic signed [SumW-1:0] BaseP2 = 30'sd200000000;
  localparam logic signed [SumW-1:0] BaseM1 = -30'sd100000000;

  localparam logic [LimbW-1:0] LimbBase = 27'd100000000;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRead = 4'b0010,
    StAdd  = 4'b0100,
    StNorm = 4'b1000
  } state_e;

endpackage
`default_nettype wire

// ----- src/decimal_limb_add_sub_compare_core.sv -----
// Top level: sign-magnitude base 10^8 multiword add/subtract with signed compare.
//
//   channel   | signals                                      | handshake
//   ----------+----------------------------------------------+--------------------------
//   request   | operation, sign_a, sign_b, limb_a, limb_b,   | start high, busy low
//             | last_limb                                    |
//   result    | result_limb, result_sign, last_result,       | result_valid_o strobe,
//             | a_less, a_equal, a_greater, overflow         | one cycle, no stall
//
// Each request pair is written to the limb memories while fewer than LIMBS are stored.
// The last pair starts a walk over the n stored pairs: a first memory read (StRead), then
// per limb a sum step (StAdd) and a normalize step with the next read (StNorm), paced by the
// carry loop through the single read port; busy stays high until the walk ends. Results
// appear in the cycle after each normalize step. Reset clears only the state, pair count,
// compare flags and result strobe; the memories need no clearing. Results cannot be stalled.
`default_nettype none
module decimal_limb_add_sub_compare_core #(
  parameter int unsigned LIMBS = 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire                          operation_i,
  input  wire                          sign_a_i,
  input  wire                          sign_b_i,
  input  wire  [dlasc_pkg::LimbW-1:0]  limb_a_i,
  input  wire  [dlasc_pkg::LimbW-1:0]  limb_b_i,
  input  wire                          last_limb_i,
  output logic                         result_valid_o,
  output logic [dlasc_pkg::LimbW-1:0]  result_limb_o,
  output logic                         result_sign_o,
  output logic                         last_result_o,
  output logic                         a_less_o,
  output logic                         a_equal_o,
  output logic                         a_greater_o,
  output logic                         overflow_o
);
  import dlasc_pkg::*;

  localparam int unsigned CntW = $clog2(LIMBS + 1);
  localparam int unsigned IdxW = (LIMBS > 1) ? $clog2(LIMBS) : 1;

  logic [LimbW-1:0] mem_a [LIMBS];
  logic [LimbW-1:0] mem_b [LIMBS];

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q, idx_d, last_idx_q, last_idx_d;
  logic gt_q, gt_d, lt_q, lt_d;
  logic swap_q, swap_d, neg_q, neg_d, sub_q, sub_d;
  logic f_lt_q, f_lt_d, f_eq_q, f_eq_d, f_gt_q, f_gt_d;
  logic signed [CarryW-1:0] carry_q, carry_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [LimbW-1:0] rd_a_q, rd_b_q;

  logic accept, stored;
  logic [CntW-1:0] n_m1;
  logic gt_in, lt_in;
  logic rd_en;
  logic [IdxW-1:0] rd_addr;
  logic is_last;
  logic signed [SumW-1:0] x_s, y_s, c_s;
  logic signed [CarryW-1:0] q_s;
  logic signed [SumW-1:0] r_s;
  logic a_big;

  assign accept = start && !busy;
  assign stored = count_q < CntW'(LIMBS);
  assign busy   = (state_q != StIdle);
  assign is_last = (idx_q == last_idx_q);

  // running magnitude compare, newest (higher) limb wins when it differs
  always_comb begin
    gt_in = gt_q;
    lt_in = lt_q;
    if (stored) begin
      if (limb_a_i > limb_b_i) begin
        gt_in = 1'b1;
        lt_in = 1'b0;
      end else if (limb_a_i < limb_b_i) begin
        gt_in = 1'b0;
        lt_in = 1'b1;
      end
    end
  end

  assign n_m1 = stored ? count_q : count_q - CntW'(1);

  always_comb begin
    x_s = swap_q ? $signed({3'b000, rd_b_q}) : $signed({3'b000, rd_a_q});
    y_s = swap_q ? $signed({3'b000, rd_a_q}) : $signed({3'b000, rd_b_q});
    c_s = {{(SumW-CarryW){carry_q[CarryW-1]}}, carry_q};
    sum_d = sub_q ? (x_s - y_s + c_s) : (x_s + y_s + c_s);
  end

  always_comb begin
    if (sum_q < BaseM1) begin
      q_s = -3'sd2;
      r_s = sum_q + BaseP2;
    end else if (sum_q < 30'sd0) begin
      q_s = -3'sd1;
      r_s = sum_q + BaseP1;
    end else if (sum_q < BaseP1) begin
      q_s = 3'sd0;
      r_s = sum_q;
    end else if (sum_q < BaseP2) begin
      q_s = 3'sd1;
      r_s = sum_q - BaseP1;
    end else begin
      q_s = 3'sd2;
      r_s = sum_q - BaseP2;
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    last_idx_d = last_idx_q;
    gt_d       = gt_q;
    lt_d       = lt_q;
    swap_d     = swap_q;
    neg_d      = neg_q;
    sub_d      = sub_q;
    f_lt_d     = f_lt_q;
    f_eq_d     = f_eq_q;
    f_gt_d     = f_gt_q;
    carry_d    = carry_q;
    rd_en      = 1'b0;
    rd_addr    = idx_q;
    a_big      = gt_in ^ sign_a_i;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (last_limb_i) begin
            last_idx_d = n_m1[IdxW-1:0];
            count_d    = '0;
            gt_d       = 1'b0;
            lt_d       = 1'b0;
            idx_d      = '0;
            carry_d    = '0;
            swap_d     = operation_i && !sign_a_i && lt_in;
            neg_d      = operation_i && (sign_a_i || lt_in);
            sub_d      = operation_i && !sign_a_i;
            if (sign_a_i != sign_b_i) begin
              f_lt_d = sign_a_i;
              f_gt_d = sign_b_i;
              f_eq_d = 1'b0;
            end else if (!gt_in && !lt_in) begin
              f_lt_d = 1'b0;
              f_gt_d = 1'b0;
              f_eq_d = 1'b1;
            end else begin
              f_gt_d = a_big;
              f_lt_d = !a_big;
              f_eq_d = 1'b0;
            end
            state_d = StRead;
          end else begin
            gt_d = gt_in;
            lt_d = lt_in;
            if (stored) begin
              count_d = count_q + CntW'(1);
            end
          end
        end
      end
      StRead: begin
        rd_en   = 1'b1;
        rd_addr = idx_q;
        state_d = StAdd;
      end
      StAdd: begin
        state_d = StNorm;
      end
      StNorm: begin
        carry_d = q_s;
        if (is_last) begin
          state_d = StIdle;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          rd_en   = 1'b1;
          rd_addr = idx_q + IdxW'(1);
          state_d = StAdd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && stored) begin
      mem_a[count_q[IdxW-1:0]] <= limb_a_i;
      mem_b[count_q[IdxW-1:0]] <= limb_b_i;
    end
    if (rd_en) begin
      rd_a_q <= mem_a[rd_addr];
      rd_b_q <= mem_b[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      count_q        <= '0;
      gt_q           <= 1'b0;
      lt_q           <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      gt_q           <= gt_d;
      lt_q           <= lt_d;
      result_valid_o <= (state_q == StNorm);
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    last_idx_q <= last_idx_d;
    swap_q     <= swap_d;
    neg_q      <= neg_d;
    sub_q      <= sub_d;
    f_lt_q     <= f_lt_d;
    f_eq_q     <= f_eq_d;
    f_gt_q     <= f_gt_d;
    carry_q    <= carry_d;
    if (state_q == StAdd) begin
      sum_q <= sum_d;
    end
    if (state_q == StNorm) begin
      result_limb_o <= r_s[LimbW-1:0];
      result_sign_o <= neg_q;
      last_result_o <= is_last;
      a_less_o      <= is_last && f_lt_q;
      a_equal_o     <= is_last && f_eq_q;
      a_greater_o   <= is_last && f_gt_q;
      overflow_o    <= is_last && (q_s != 3'sd0);
    end
  end

endmodule
`default_nettype wire

// ----- src/dlasc_checker.sv -----
// Port-level checker for the decimal limb add/subtract/compare core, with its bind.
`default_nettype none
module dlasc_checker (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         start,
  input wire                         busy,
  input wire                         last_limb_i,
  input wire                         result_valid_o,
  input wire [dlasc_pkg::LimbW-1:0]  result_limb_o,
  input wire                         last_result_o,
  input wire                         a_less_o,
  input wire                         a_equal_o,
  input wire                         a_greater_o,
  input wire                         overflow_o
);
  import dlasc_pkg::*;

  a_last_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_limb_i |=> busy)
    else $error("last request did not start the walk");

  a_result_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe outside a walk");

  a_limb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_limb_o < LimbBase))
    else $error("result limb out of range");

  a_flags_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_result_o |-> $onehot({a_less_o, a_equal_o, a_greater_o}))
    else $error("compare flags not one-hot on last result");

  a_flags_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |->
      !(a_less_o || a_equal_o || a_greater_o || overflow_o))
    else $error("flags set on an inner result limb");

endmodule

bind decimal_limb_add_sub_compare_core dlasc_checker u_dlasc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .last_limb_i    (last_limb_i),
  .result_valid_o (result_valid_o),
  .result_limb_o  (result_limb_o),
  .last_result_o  (last_result_o),
  .a_less_o       (a_less_o),
  .a_equal_o      (a_equal_o),
  .a_greater_o    (a_greater_o),
  .overflow_o     (overflow_o)
);
`default_nettype wire
